/* hdl/assert_macros.svh */
// Assertion macros used by the port-level checker.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is high.
`define SPQ_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Next-cycle implication, held off while reset is high.
`define SPQ_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

/* hdl/spq_pkg.sv */
// Shared types and constants for the stable priority queue.
// No dependencies; imported by every module of the block.
`default_nettype none

package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int FILL_W   = 5;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_PEEK   = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Shift commands broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;
    logic remove;
  } spq_shift_t;

endpackage

`default_nettype wire

/* hdl/spq_cell.sv */
// One slot of the sorted chain: holds a value and priority, shifts with neighbors.
// Depends on spq_pkg.
`default_nettype none

module spq_cell import spq_pkg::*; (
  input  wire logic                     clk,
  input  wire spq_shift_t               ctl,
  input  wire logic                     occupied,
  input  wire logic                     stay_prev,
  input  wire logic signed [DATA_W-1:0] new_value,
  input  wire logic signed [DATA_W-1:0] new_prio,
  input  wire logic signed [DATA_W-1:0] prev_value,
  input  wire logic signed [DATA_W-1:0] prev_prio,
  input  wire logic signed [DATA_W-1:0] next_value,
  input  wire logic signed [DATA_W-1:0] next_prio,
  output logic                          stay,
  output logic signed [DATA_W-1:0]      ent_value,
  output logic signed [DATA_W-1:0]      ent_prio
);

  // Held entries at or above the new priority keep their slot (FIFO on ties).
  assign stay = occupied && (ent_prio >= new_prio);

  always_ff @(posedge clk) begin
    if (ctl.insert && !stay) begin
      if (stay_prev) begin
        ent_value <= new_value;
        ent_prio  <= new_prio;
      end else begin
        ent_value <= prev_value;
        ent_prio  <= prev_prio;
      end
    end else if (ctl.remove) begin
      ent_value <= next_value;
      ent_prio  <= next_prio;
    end
  end

endmodule

`default_nettype wire

/* hdl/stable_priority_queue_unit.sv */
// Top level of the stable priority queue: request decode, fill count and cell chain.
// Depends on spq_pkg and spq_cell.
//
//  channel   | handshake          | fields
//  ----------+--------------------+-----------------------------------
//  request   | start / busy       | req_type, in_value, in_priority
//  result    | done (1-cycle)     | status, out_value, fill_count
//
// One request per cycle while busy is low: every cell compares the new priority against its own
// in parallel and the whole chain shifts in the cycle of the transfer.
// The result appears on the cycle after the transfer, strobed by done.
// busy is high only while rst is high; there is no clearing pass since the
// store contents below fill count are always written before being read.
// The receiver cannot stall; results are never held back.
`default_nettype none

module stable_priority_queue_unit import spq_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [1:0]               req_type,
  input  wire logic signed [DATA_W-1:0] in_value,
  input  wire logic signed [DATA_W-1:0] in_priority,
  output logic                          done,
  output logic [1:0]                    status,
  output logic signed [DATA_W-1:0]      out_value,
  output logic [FILL_W-1:0]             fill_count
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             accept;
  logic             is_full;
  logic             is_empty;
  spq_shift_t       shift;
  status_t          res_status;
  logic signed [DATA_W-1:0] res_value;

  // Chain state: one entry per cell, slot 0 is the head of the queue.
  logic signed [DATA_W-1:0] cell_value [CAPACITY];
  logic signed [DATA_W-1:0] cell_prio  [CAPACITY];
  logic                     cell_stay  [CAPACITY];

  assign busy     = rst;
  assign accept   = start && !busy;
  assign is_full  = (count == CNT_W'(CAPACITY));
  assign is_empty = (count == '0);

  // Request decode: shift command, next fill count and the result fields.
  always_comb begin
    shift      = '0;
    count_next = count;
    res_status = ST_OK;
    res_value  = '0;
    if (accept) begin
      unique case (req_type)
        REQ_INSERT: begin
          if (is_full) begin
            res_status = ST_FULL;
          end else begin
            shift.insert = 1'b1;
            count_next   = count + CNT_W'(1);
          end
        end
        REQ_REMOVE: begin
          if (is_empty) begin
            res_status = ST_EMPTY;
          end else begin
            shift.remove = 1'b1;
            res_value    = cell_value[0];
            count_next   = count - CNT_W'(1);
          end
        end
        REQ_PEEK: begin
          if (is_empty) begin
            res_status = ST_EMPTY;
          end else begin
            res_value = cell_value[0];
          end
        end
        REQ_CLEAR: begin
          count_next = '0;
        end
        default: begin
          count_next = count;
        end
      endcase
    end
  end

  // The chain. Cell 0 takes a new entry whenever it cannot stay; the last
  // cell shifts in its own contents on a remove (that slot becomes unused).
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     stay_prev;
    logic signed [DATA_W-1:0] prev_value;
    logic signed [DATA_W-1:0] prev_prio;
    logic signed [DATA_W-1:0] next_value;
    logic signed [DATA_W-1:0] next_prio;

    if (i == 0) begin : g_head
      assign stay_prev  = 1'b1;
      assign prev_value = in_value;
      assign prev_prio  = in_priority;
    end else begin : g_body
      assign stay_prev  = cell_stay[i-1];
      assign prev_value = cell_value[i-1];
      assign prev_prio  = cell_prio[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_value = cell_value[i];
      assign next_prio  = cell_prio[i];
    end else begin : g_inner
      assign next_value = cell_value[i+1];
      assign next_prio  = cell_prio[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctl        (shift),
      .occupied   (CNT_W'(i) < count),
      .stay_prev  (stay_prev),
      .new_value  (in_value),
      .new_prio   (in_priority),
      .prev_value (prev_value),
      .prev_prio  (prev_prio),
      .next_value (next_value),
      .next_prio  (next_prio),
      .stay       (cell_stay[i]),
      .ent_value  (cell_value[i]),
      .ent_prio   (cell_prio[i])
    );
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  // Result payload, qualified by done.
  always_ff @(posedge clk) begin
    status     <= res_status;
    out_value  <= res_value;
    fill_count <= FILL_W'(count_next);
  end

endmodule

`default_nettype wire

/* hdl/spq_checker.sv */
// Port-level checker for the stable priority queue, bound to the top level.
// Depends on spq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module spq_checker import spq_pkg::*; (
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     start,
  input wire logic                     busy,
  input wire logic [1:0]               req_type,
  input wire logic                     done,
  input wire logic [1:0]               status,
  input wire logic signed [DATA_W-1:0] out_value,
  input wire logic [FILL_W-1:0]        fill_count
);

  logic xfer;
  logic clr_xfer;
  logic clr_ok;
  logic empty_rsp;
  logic empty_ok;
  logic full_rsp;
  logic full_ok;

  assign xfer      = start && !busy;
  assign clr_xfer  = xfer && (req_type == REQ_CLEAR);
  assign clr_ok    = (fill_count == '0) && (status == ST_OK);
  assign empty_rsp = done && (status == ST_EMPTY);
  assign empty_ok  = (out_value == '0) && (fill_count == '0);
  assign full_rsp  = done && (status == ST_FULL);
  assign full_ok   = (out_value == '0) && (fill_count == FILL_W'(CAPACITY));

  `SPQ_ASSERT_NEXT(a_done_follows, clk, rst, xfer, done)
  `SPQ_ASSERT_NEXT(a_no_spurious, clk, rst, !xfer, !done)
  `SPQ_ASSERT_NEXT(a_clear_empties, clk, rst, clr_xfer, clr_ok)
  `SPQ_ASSERT_NOW(a_empty_result, clk, rst, empty_rsp, empty_ok)
  `SPQ_ASSERT_NOW(a_full_result, clk, rst, full_rsp, full_ok)

endmodule

bind stable_priority_queue_unit spq_checker u_spq_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .req_type   (req_type),
  .done       (done),
  .status     (status),
  .out_value  (out_value),
  .fill_count (fill_count)
);

`default_nettype wire

/* sim/tb_stable_priority_queue_unit.sv */
// Self-checking testbench for stable_priority_queue_unit: directed and random requests,
// a sorted-store predictor and a per-field check of every result.
// Depends on spq_pkg and the RTL of the block; reads no files.
module tb_stable_priority_queue_unit import spq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM   = 1930; // random requests after the directed part
  localparam int STALL_MAX  = 1000; // cycles with no activity before giving up
  localparam int DRAIN_WAIT = 4;    // cycles after the last result
  localparam int PRINT_MAX  = 40;   // cap on mismatch lines

  // One request as the driver presents it, with the sender idle rate of its phase.
  typedef struct {
    req_t                     kind;
    logic signed [DATA_W-1:0] val;
    logic signed [DATA_W-1:0] pri;
    int                       idle_pct;
  } pq_req_t;

  // One result as the block should report it.
  typedef struct {
    status_t                  st;
    logic signed [DATA_W-1:0] val;
    logic [FILL_W-1:0]        fill;
  } pq_rsp_t;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [1:0]               req_type;
  logic signed [DATA_W-1:0] in_value;
  logic signed [DATA_W-1:0] in_priority;
  logic                     done;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] out_value;
  logic [FILL_W-1:0]        fill_count;

  pq_req_t pending_reqs[$];   // requests still to be presented
  pq_rsp_t expected_rsps[$];  // results owed by accepted requests

  // Predictor copy of the sorted store: position 0 holds the top entry.
  logic signed [DATA_W-1:0] held_val[CAPACITY];
  logic signed [DATA_W-1:0] held_pri[CAPACITY];
  int unsigned              held_cnt;

  int   err_count;
  int   n_accepted;
  int   n_total;
  int   quiet_cycles;
  logic xfer_seen;  // a transfer happened at the last rising edge

  stable_priority_queue_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .in_value    (in_value),
    .in_priority (in_priority),
    .done        (done),
    .status      (status),
    .out_value   (out_value),
    .fill_count  (fill_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(string msg);
    if (err_count < PRINT_MAX) begin
      $display("ERROR %0t: %s", $realtime, msg);
    end
    err_count++;
  endtask

  task automatic add_req(req_t kind, logic signed [DATA_W-1:0] val,
                         logic signed [DATA_W-1:0] pri, int idle_pct);
    pq_req_t r;
    r.kind     = kind;
    r.val      = val;
    r.pri      = pri;
    r.idle_pct = idle_pct;
    pending_reqs.push_back(r);
  endtask

  // Applies one accepted request to the predictor store and returns its result.
  function automatic pq_rsp_t queue_apply(req_t kind, logic signed [DATA_W-1:0] val,
                                          logic signed [DATA_W-1:0] pri);
    pq_rsp_t     rsp;
    int unsigned pos;
    int unsigned k;
    rsp.st  = ST_OK;
    rsp.val = '0;
    case (kind)
      REQ_INSERT: begin
        if (held_cnt >= CAPACITY) begin
          rsp.st = ST_FULL;
        end else begin
          // stable order: go behind every entry of equal or higher priority
          pos = 0;
          while (pos < held_cnt && held_pri[pos] >= pri) pos++;
          for (k = held_cnt; k > pos; k--) begin
            held_val[k] = held_val[k-1];
            held_pri[k] = held_pri[k-1];
          end
          held_val[pos] = val;
          held_pri[pos] = pri;
          held_cnt++;
        end
      end
      REQ_REMOVE: begin
        if (held_cnt == 0) begin
          rsp.st = ST_EMPTY;
        end else begin
          rsp.val = held_val[0];
          for (k = 1; k < held_cnt; k++) begin
            held_val[k-1] = held_val[k];
            held_pri[k-1] = held_pri[k];
          end
          held_cnt--;
        end
      end
      REQ_PEEK: begin
        if (held_cnt == 0) rsp.st = ST_EMPTY;
        else rsp.val = held_val[0];
      end
      default: begin
        held_cnt = 0;
      end
    endcase
    rsp.fill = FILL_W'(held_cnt);
    return rsp;
  endfunction

  // Driver: inputs move on the falling edge only. A new request is picked once the
  // previous one has made its transfer; the per-phase idle rate inserts gaps, and
  // the payload ports carry noise whenever start is low out of reset.
  always @(negedge clk) begin
    pq_req_t r;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || xfer_seen) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= pending_reqs[0].idle_pct) begin
        r = pending_reqs.pop_front();
        start       <= 1'b1;
        req_type    <= r.kind;
        in_value    <= r.val;
        in_priority <= r.pri;
      end else begin
        start       <= 1'b0;
        req_type    <= 2'($urandom);
        in_value    <= $urandom;
        in_priority <= $urandom;
      end
    end
  end

  // Monitor: at each rising edge first check a strobed result against the oldest
  // expectation, then log the transfer (if any) into the predictor. The result of
  // a transfer comes in the following cycle, so it is never checked at its own edge.
  always @(posedge clk) begin
    pq_rsp_t want;
    if (rst) begin
      xfer_seen <= 1'b0;
    end else begin
      if (done) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("result strobe with no request outstanding");
        end else begin
          want = expected_rsps.pop_front();
          if (status !== want.st)
            report_mismatch($sformatf("status got %0d expected %0d", status, want.st));
          if (out_value !== want.val)
            report_mismatch($sformatf("out_value got %0d expected %0d", out_value, want.val));
          if (fill_count !== want.fill)
            report_mismatch($sformatf("fill_count got %0d expected %0d",
                                      fill_count, want.fill));
        end
      end
      if (start && !busy) begin
        expected_rsps.push_back(queue_apply(req_t'(req_type), in_value, in_priority));
        n_accepted <= n_accepted + 1;
      end
      xfer_seen <= start && !busy;
    end
  end

  // Watchdog: any transfer or result resets the count of quiet cycles.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_MAX) begin
      $display("FAIL stable_priority_queue_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int   mode;
    int   pick;
    int   idle;
    req_t kind;
    logic signed [DATA_W-1:0] val;
    logic signed [DATA_W-1:0] pri;
    logic signed [DATA_W-1:0] extremes[4];

    rst          = 1'b1;
    start        = 1'b0;
    req_type     = REQ_PEEK;
    in_value     = '0;
    in_priority  = '0;
    held_cnt     = 0;
    err_count    = 0;
    n_accepted   = 0;
    quiet_cycles = 0;
    xfer_seen    = 1'b0;
    extremes     = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sd0, -32'sd1};

    // Directed part: empty reads, extreme fields, priority ties, full store,
    // ignored payload on non-insert requests, clear.
    add_req(REQ_PEEK,   32'sh5a5a_a5a5, 32'sh7fff_ffff, 0);
    add_req(REQ_REMOVE, -32'sd1, 32'sh8000_0000, 0);
    add_req(REQ_INSERT, 32'sh7fff_ffff, 32'sh7fff_ffff, 0);
    add_req(REQ_INSERT, 32'sh8000_0000, 32'sh8000_0000, 0);
    add_req(REQ_INSERT, 32'sd0, 32'sd0, 0);
    add_req(REQ_INSERT, -32'sd1, -32'sd1, 0);
    add_req(REQ_INSERT, 32'sd1, 32'sd0, 0);            // ties with an earlier entry
    add_req(REQ_INSERT, 32'sd2, 32'sh7fff_ffff, 0);    // ties at the top
    for (int i = 0; i < 10; i++) begin
      add_req(REQ_INSERT, 100 + i, (i % 3) - 1, 0);    // store now full
    end
    add_req(REQ_INSERT, 32'sh1234_5678, 32'sh7fff_ffff, 0);  // dropped
    add_req(REQ_PEEK,   32'sh0f0f_0f0f, 32'sh7fff_ffff, 0);
    add_req(REQ_REMOVE, 32'shf0f0_f0f0, 32'sh8000_0000, 0);
    add_req(REQ_REMOVE, 32'sd0, 32'sd0, 0);
    add_req(REQ_CLEAR,  -32'sd1, -32'sd1, 0);
    add_req(REQ_REMOVE, 32'sd7, 32'sd7, 0);
    add_req(REQ_PEEK,   32'sd9, 32'sd9, 0);

    // Random part: the request mix drifts between filling, draining and balanced
    // so the store swings between empty and full. Half of the priorities lie in a narrow
    // band to force ties, the rest are full range or extremes. The four quarters run
    // with sender idle rates of 0, 62, 0 and 27 percent.
    mode = 0;
    for (int i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(39) == 0) mode = $urandom_range(2);
      case ((4 * i) / N_RANDOM)
        1:       idle = 62;
        3:       idle = 27;
        default: idle = 0;
      endcase
      pick = $urandom_range(99);
      if (pick == 0) kind = REQ_CLEAR;
      else if (pick < (mode == 0 ? 76 : mode == 1 ? 26 : 46)) kind = REQ_INSERT;
      else if (pick < (mode == 0 ? 90 : mode == 1 ? 82 : 80)) kind = REQ_REMOVE;
      else kind = REQ_PEEK;
      pick = $urandom_range(99);
      if (pick < 50) pri = $signed($urandom_range(6)) - 3;
      else if (pick < 80) pri = $urandom;
      else pri = extremes[$urandom_range(3)];
      val = ($urandom_range(9) == 0) ? extremes[$urandom_range(3)] : $signed($urandom);
      add_req(kind, val, pri, idle);
    end
    n_total = pending_reqs.size();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (n_accepted < n_total || expected_rsps.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_rsps.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_rsps.size()));

    if (err_count == 0) begin
      $display("PASS stable_priority_queue_unit");
    end else begin
      $display("FAIL stable_priority_queue_unit");
    end
    $finish;
  end

endmodule
